// ===== hdl/wpm_pkg.sv =====
// Shared constants, types and helper functions of the wildcard pattern matcher.
`timescale 1ns / 1ps
package wpm_pkg;

    localparam int PATTERN_MAX = 32;
    localparam int LEN_W       = $clog2(PATTERN_MAX + 1);
    localparam int SYM_W       = 8;
    localparam int KIND_W      = 2;

    localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_APPEND = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TEXT   = 2'd2;
    localparam logic [KIND_W-1:0] KIND_END    = 2'd3;

    localparam logic [SYM_W-1:0] SYM_STAR     = 8'h2A;
    localparam logic [SYM_W-1:0] SYM_QUESTION = 8'h3F;
    localparam logic [SYM_W-1:0] SYM_UPPER_A  = 8'h41;
    localparam logic [SYM_W-1:0] SYM_UPPER_Z  = 8'h5A;
    localparam logic [SYM_W-1:0] SYM_LOWER_A  = 8'h61;

    typedef logic [PATTERN_MAX:0] t_pos_vec;

    typedef struct packed {
        logic wr_en;
        logic load;
        logic init;
        logic used;
        logic act_n;
    } t_cell_ctl;

    typedef struct packed {
        logic act;
        logic star_n;
        logic fwd;
        logic stay;
    } t_cell_stat;

    function automatic logic [SYM_W-1:0] fold_case(input logic [SYM_W-1:0] c);
        logic [SYM_W-1:0] r;
        r = c;
        if ((c >= SYM_UPPER_A) && (c <= SYM_UPPER_Z)) begin
            r = c - SYM_UPPER_A + SYM_LOWER_A;
        end
        return r;
    endfunction

endpackage

// ===== hdl/wpm_cell.sv =====
// One pattern position: stored symbol, active bit and the per-symbol match step.
`timescale 1ns / 1ps
module wpm_cell (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  wpm_pkg::t_cell_ctl         i_ctl,
    input  logic [wpm_pkg::SYM_W-1:0]  i_sym,
    output wpm_pkg::t_cell_stat        o_stat
);
    import wpm_pkg::*;

    logic [SYM_W-1:0] r_sym;
    logic [SYM_W-1:0] n_sym;
    logic             r_act;
    logic             n_act;
    logic             star_cur;
    logic             sym_match;

    assign star_cur  = (r_sym == SYM_STAR);
    assign sym_match = (r_sym == SYM_QUESTION) || (fold_case(r_sym) == fold_case(i_sym));

    always_comb begin
        n_sym = i_ctl.wr_en ? i_sym : r_sym;
        n_act = i_ctl.load ? i_ctl.act_n : r_act;
    end

    always_ff @(posedge i_clk) begin
        r_sym <= n_sym;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act <= i_ctl.init;
        end else begin
            r_act <= n_act;
        end
    end

    assign o_stat.act    = r_act;
    assign o_stat.star_n = i_ctl.wr_en ? (i_sym == SYM_STAR) : star_cur;
    assign o_stat.fwd    = r_act && i_ctl.used && !star_cur && sym_match;
    assign o_stat.stay   = r_act && i_ctl.used && star_cur;

endmodule

// ===== hdl/wpm_closure.sv =====
// Star closure of a position set, done as a carry chain through runs of stars.
`timescale 1ns / 1ps
module wpm_closure (
    input  wpm_pkg::t_pos_vec i_seed,
    input  wpm_pkg::t_pos_vec i_prop,
    output wpm_pkg::t_pos_vec o_act
);
    import wpm_pkg::*;

    t_pos_vec gen;
    t_pos_vec sum;
    t_pos_vec carry;

    // A carry enters position i+1 when an active star at or below i is
    // followed only by stars up to i.
    assign gen   = i_seed & i_prop;
    assign sum   = gen + i_prop;
    assign carry = sum ^ gen ^ i_prop;
    assign o_act = i_seed | carry;

endmodule

// ===== hdl/wildcard_pattern_matcher_unit.sv =====
// Top level of the wildcard pattern matcher: a row of position cells and a verdict register.
// Throughput: one transaction per cycle, in every kind, with no gaps while the result side does not stall.
// The verdict of an end-of-text transaction is registered and shown in the cycle after its acceptance.
// Each accepted transaction updates the cell row through the closure carry chain.
// Reset is synchronous: the pattern is empty, overflow is clear and position zero is active.
// Stored pattern symbols are not cleared by reset; only positions below the length are used.
`timescale 1ns / 1ps
module wildcard_pattern_matcher_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [wpm_pkg::KIND_W-1:0]  i_kind,
    input  logic [wpm_pkg::SYM_W-1:0]   i_symbol,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic                        o_matched,
    output logic                        o_pattern_overflow
);
    import wpm_pkg::*;

    logic [LEN_W-1:0] r_len;
    logic [LEN_W-1:0] n_len;
    logic             r_ovf;
    logic             n_ovf;
    logic             r_act_end;
    logic             n_act_end;
    logic             r_out_valid;
    logic             n_out_valid;
    logic             r_matched;
    logic             r_out_ovf;

    logic             acc;
    logic             is_text;
    logic             is_end;
    logic             full;

    t_cell_ctl        cell_ctl  [PATTERN_MAX];
    t_cell_stat       cell_stat [PATTERN_MAX];

    t_pos_vec         act_all;
    t_pos_vec         pre;
    t_pos_vec         prop;
    t_pos_vec         seed;
    t_pos_vec         clos;

    assign acc     = i_valid && !o_stall;
    assign is_text = (i_kind == KIND_TEXT);
    assign is_end  = (i_kind == KIND_END);
    assign full    = (r_len == LEN_W'(PATTERN_MAX));

    always_comb begin
        n_len = r_len;
        n_ovf = r_ovf;
        if (acc) begin
            case (i_kind)
                KIND_CLEAR: begin
                    n_len = '0;
                    n_ovf = 1'b0;
                end
                KIND_APPEND: begin
                    if (full) begin
                        n_ovf = 1'b1;
                    end else begin
                        n_len = r_len + LEN_W'(1);
                    end
                end
                default: begin
                    n_len = r_len;
                end
            endcase
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < PATTERN_MAX; gi++) begin : g_cell
            assign cell_ctl[gi].wr_en = acc && (i_kind == KIND_APPEND)
                                        && (r_len == LEN_W'(gi));
            assign cell_ctl[gi].load  = acc;
            assign cell_ctl[gi].init  = (gi == 0);
            assign cell_ctl[gi].used  = (LEN_W'(gi) < r_len);
            assign cell_ctl[gi].act_n = clos[gi];

            wpm_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctl   (cell_ctl[gi]),
                .i_sym   (i_symbol),
                .o_stat  (cell_stat[gi])
            );

            assign act_all[gi] = cell_stat[gi].act;
            assign prop[gi]    = cell_stat[gi].star_n && (LEN_W'(gi) < n_len);
            if (gi == 0) begin : g_first
                assign pre[gi] = cell_stat[gi].stay;
            end else begin : g_rest
                assign pre[gi] = cell_stat[gi].stay || cell_stat[gi-1].fwd;
            end
        end
    endgenerate

    assign act_all[PATTERN_MAX] = r_act_end;
    assign prop[PATTERN_MAX]    = 1'b0;
    assign pre[PATTERN_MAX]     = cell_stat[PATTERN_MAX-1].fwd;

    // Every non-text transaction re-arms the set from position zero under the new pattern.
    assign seed = is_text ? pre : t_pos_vec'(1);

    wpm_closure u_closure (
        .i_seed (seed),
        .i_prop (prop),
        .o_act  (clos)
    );

    always_comb begin
        n_act_end   = acc ? clos[PATTERN_MAX] : r_act_end;
        n_out_valid = r_out_valid && i_stall;
        if (acc && is_end) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= '0;
            r_ovf       <= 1'b0;
            r_act_end   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_len       <= n_len;
            r_ovf       <= n_ovf;
            r_act_end   <= n_act_end;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc && is_end) begin
            r_matched <= act_all[r_len] && !r_ovf;
            r_out_ovf <= r_ovf;
        end
    end

    assign o_stall            = r_out_valid && i_stall;
    assign o_valid            = r_out_valid;
    assign o_matched          = r_matched;
    assign o_pattern_overflow = r_out_ovf;

endmodule

// ===== hdl/wpm_checker.sv =====
// Port-level assertions for the wildcard pattern matcher and their bind to the top level.
`timescale 1ns / 1ps
module wpm_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_valid,
    input logic                        o_stall,
    input logic [wpm_pkg::KIND_W-1:0]  i_kind,
    input logic [wpm_pkg::SYM_W-1:0]   i_symbol,
    input logic                        o_valid,
    input logic                        i_stall,
    input logic                        o_matched,
    input logic                        o_pattern_overflow
);
    import wpm_pkg::*;

    logic in_acc;
    assign in_acc = i_valid && !o_stall;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_matched)
                                  && $stable(o_pattern_overflow)))
        else $error("stalled result transaction changed or was dropped");

    a_ovf_forces_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_pattern_overflow) |-> !o_matched)
        else $error("match reported with pattern overflow");

    a_end_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (i_kind == KIND_END)) |=> o_valid)
        else $error("end-of-text transaction produced no result");

    a_result_has_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(in_acc && (i_kind == KIND_END)))
        else $error("result transaction without an end-of-text transaction");

    a_clear_resets_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (i_kind == KIND_CLEAR)) ##1 (in_acc && (i_kind == KIND_END))
        |=> !o_pattern_overflow)
        else $error("overflow reported right after a clear");

endmodule

bind wildcard_pattern_matcher_unit wpm_checker u_wpm_checker (.*);

// ===== tb/sv/wildcard_pattern_matcher_unit_tb.sv =====
// Self-checking testbench of the wildcard pattern matcher: directed table, then random traffic.
`timescale 1ns / 1ps
module wildcard_pattern_matcher_unit_tb;
    import wpm_pkg::*;

    localparam int ITEM_TARGET = 1600;
    localparam int IDLE_LIMIT  = 2000;
    localparam int DRAIN_WAIT  = 8;

    typedef struct packed {
        logic matched;
        logic overflow;
    } t_verdict;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [SYM_W-1:0]  sym;
        logic [5:0]        rep;
        logic              fixed;
        logic              matched;
        logic              overflow;
    } t_plan_row;

    logic              i_clk              = 1'b0;
    logic              i_rst_n            = 1'b0;
    logic              i_valid            = 1'b0;
    logic [KIND_W-1:0] i_kind             = KIND_CLEAR;
    logic [SYM_W-1:0]  i_symbol           = '0;
    logic              i_stall            = 1'b0;
    logic              o_stall;
    logic              o_valid;
    logic              o_matched;
    logic              o_pattern_overflow;

    wildcard_pattern_matcher_unit i_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_kind             (i_kind),
        .i_symbol           (i_symbol),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_matched          (o_matched),
        .o_pattern_overflow (o_pattern_overflow)
    );

    // Shadow copy of the matcher state.
    logic [SYM_W-1:0] pat_sym [PATTERN_MAX];
    int               pat_len  = 0;
    logic             pat_ovf  = 1'b0;
    t_pos_vec         live_pos = t_pos_vec'(1);

    t_verdict         verdict_q [$];
    logic [SYM_W-1:0] gen_pat [$];

    int err_cnt       = 0;
    int items_sent    = 0;
    int verdicts_seen = 0;
    int match_seen    = 0;
    int ovf_seen      = 0;
    int burst_left    = 0;
    int idle_cycles   = 0;

    int stall_mode = 0;
    int mode_left  = 0;
    int stall_per  = 2;
    int stall_on   = 1;
    int stall_ph   = 0;

    t_plan_row plan [27] = '{
        '{KIND_END,    8'h00,        6'd1,  1'b1, 1'b1, 1'b0},
        '{KIND_TEXT,   8'h78,        6'd1,  1'b0, 1'b0, 1'b0},
        '{KIND_END,    8'h00,        6'd1,  1'b1, 1'b0, 1'b0},
        '{KIND_APPEND, 8'h41,        6'd1,  1'b0, 1'b0, 1'b0},
        '{KIND_APPEND, SYM_STAR,     6'd1,  1'b0, 1'b0, 1'b0},
        '{KIND_APPEND, SYM_QUESTION, 6'd1,  1'b0, 1'b0, 1'b0},
        '{KIND_APPEND, 8'h00,        6'd1,  1'b0, 1'b0, 1'b0},
        '{KIND_TEXT,   8'h61,        6'd1,  1'b0, 1'b0, 1'b0},
        '{KIND_TEXT,   8'h51,        6'd1,  1'b0, 1'b0, 1'b0},
        '{KIND_TEXT,   8'h7A,        6'd1,  1'b0, 1'b0, 1'b0},
        '{KIND_TEXT,   8'h00,        6'd1,  1'b0, 1'b0, 1'b0},
        '{KIND_END,    8'hFF,        6'd1,  1'b0, 1'b0, 1'b0},
        '{KIND_TEXT,   8'hFF,        6'd1,  1'b0, 1'b0, 1'b0},
        '{KIND_APPEND, 8'hFF,        6'd1,  1'b0, 1'b0, 1'b0},
        '{KIND_END,    8'h00,        6'd1,  1'b0, 1'b0, 1'b0},
        '{KIND_CLEAR,  8'hFF,        6'd1,  1'b0, 1'b0, 1'b0},
        '{KIND_APPEND, 8'h40,        6'd1,  1'b0, 1'b0, 1'b0},
        '{KIND_TEXT,   8'h60,        6'd1,  1'b0, 1'b0, 1'b0},
        '{KIND_END,    8'h00,        6'd1,  1'b0, 1'b0, 1'b0},
        '{KIND_APPEND, SYM_STAR,     6'd31, 1'b0, 1'b0, 1'b0},
        '{KIND_TEXT,   8'h40,        6'd1,  1'b0, 1'b0, 1'b0},
        '{KIND_END,    8'h00,        6'd1,  1'b0, 1'b0, 1'b0},
        '{KIND_APPEND, 8'h71,        6'd1,  1'b0, 1'b0, 1'b0},
        '{KIND_TEXT,   8'h40,        6'd1,  1'b0, 1'b0, 1'b0},
        '{KIND_END,    8'h00,        6'd1,  1'b1, 1'b0, 1'b1},
        '{KIND_CLEAR,  8'h00,        6'd1,  1'b0, 1'b0, 1'b0},
        '{KIND_END,    8'h00,        6'd1,  1'b1, 1'b1, 1'b0}
    };

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    function automatic logic [SYM_W-1:0] lower_ascii(input logic [SYM_W-1:0] c);
        if (c >= 8'h41 && c <= 8'h5A) begin
            return c + 8'h20;
        end
        return c;
    endfunction

    function automatic t_pos_vec close_stars(input t_pos_vec v);
        t_pos_vec r;
        r = v;
        for (int i = 0; i < pat_len; i++) begin
            if (r[i] && pat_sym[i] == SYM_STAR) begin
                r[i+1] = 1'b1;
            end
        end
        return r;
    endfunction

    function automatic t_pos_vec step_positions(input logic [SYM_W-1:0] s);
        t_pos_vec nxt;
        nxt = '0;
        for (int i = 0; i < pat_len; i++) begin
            if (live_pos[i]) begin
                if (pat_sym[i] == SYM_STAR) begin
                    nxt[i] = 1'b1;
                end else if (pat_sym[i] == SYM_QUESTION
                             || lower_ascii(pat_sym[i]) == lower_ascii(s)) begin
                    nxt[i+1] = 1'b1;
                end
            end
        end
        return close_stars(nxt);
    endfunction

    task automatic track_item(input logic [KIND_W-1:0] k, input logic [SYM_W-1:0] s,
                              output bit has, output t_verdict v);
        has = 1'b0;
        v   = '0;
        case (k)
            KIND_CLEAR: begin
                pat_len  = 0;
                pat_ovf  = 1'b0;
                live_pos = close_stars(t_pos_vec'(1));
            end
            KIND_APPEND: begin
                if (pat_len < PATTERN_MAX) begin
                    pat_sym[pat_len] = s;
                    pat_len++;
                end else begin
                    pat_ovf = 1'b1;
                end
                live_pos = close_stars(t_pos_vec'(1));
            end
            KIND_TEXT: begin
                live_pos = step_positions(s);
            end
            default: begin
                has        = 1'b1;
                v.matched  = live_pos[pat_len] && !pat_ovf;
                v.overflow = pat_ovf;
                live_pos   = close_stars(t_pos_vec'(1));
            end
        endcase
    endtask

    // Called at a rising edge; returns at the edge where the transaction is accepted.
    task automatic drive_item(input logic [KIND_W-1:0] k, input logic [SYM_W-1:0] s,
                              input bit use_fixed, input t_verdict fixed_v);
        int       gap;
        bit       has;
        t_verdict v;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        i_valid  <= 1'b1;
        i_kind   <= k;
        i_symbol <= s;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        burst_left--;
        items_sent++;
        track_item(k, s, has, v);
        if (has) begin
            verdict_q.push_back(use_fixed ? fixed_v : v);
        end
    endtask

    function automatic logic [SYM_W-1:0] maybe_flip_case(input logic [SYM_W-1:0] c);
        if (((c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A))
            && $urandom_range(0, 1)) begin
            return c ^ 8'h20;
        end
        return c;
    endfunction

    function automatic logic [SYM_W-1:0] pick_text_char();
        if ($urandom_range(0, 4) == 0) begin
            return SYM_W'($urandom_range(0, 255));
        end
        return maybe_flip_case(SYM_W'(8'h61 + $urandom_range(0, 2)));
    endfunction

    function automatic logic [SYM_W-1:0] pick_pattern_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 25) begin
            return SYM_STAR;
        end else if (r < 40) begin
            return SYM_QUESTION;
        end else if (r < 85) begin
            return maybe_flip_case(SYM_W'(8'h61 + $urandom_range(0, 2)));
        end
        return SYM_W'($urandom_range(0, 255));
    endfunction

    task automatic load_random_pattern();
        int               n;
        logic [SYM_W-1:0] c;
        drive_item(KIND_CLEAR, SYM_W'($urandom_range(0, 255)), 1'b0, '0);
        n = ($urandom_range(0, 19) == 0) ? $urandom_range(30, 36) : $urandom_range(0, 8);
        gen_pat.delete();
        for (int i = 0; i < n; i++) begin
            c = pick_pattern_char();
            gen_pat.push_back(c);
            drive_item(KIND_APPEND, c, 1'b0, '0);
        end
    endtask

    task automatic send_random_text();
        logic [SYM_W-1:0] txt [$];
        int               r;
        if ($urandom_range(0, 4) == 0) begin
            repeat ($urandom_range(0, 10)) txt.push_back(pick_text_char());
        end else begin
            foreach (gen_pat[i]) begin
                if (gen_pat[i] == SYM_STAR) begin
                    repeat ($urandom_range(0, 3)) txt.push_back(pick_text_char());
                end else if (gen_pat[i] == SYM_QUESTION) begin
                    txt.push_back(pick_text_char());
                end else begin
                    txt.push_back(maybe_flip_case(gen_pat[i]));
                end
            end
            if ($urandom_range(0, 9) < 3) begin
                r = $urandom_range(0, 2);
                if (r == 0) begin
                    txt.push_back(pick_text_char());
                end else if (txt.size() > 0 && r == 1) begin
                    void'(txt.pop_back());
                end else if (txt.size() > 0) begin
                    txt[$urandom_range(0, txt.size() - 1)] = pick_text_char();
                end
            end
        end
        foreach (txt[i]) drive_item(KIND_TEXT, txt[i], 1'b0, '0);
        drive_item(KIND_END, SYM_W'($urandom_range(0, 255)), 1'b0, '0);
    endtask

    task automatic check_verdict();
        t_verdict e;
        if (verdict_q.size() == 0) begin
            $display("%0t: unexpected verdict matched %0b overflow %0b",
                     $time, o_matched, o_pattern_overflow);
            err_cnt++;
        end else begin
            e = verdict_q.pop_front();
            verdicts_seen++;
            if (o_matched) match_seen++;
            if (o_pattern_overflow) ovf_seen++;
            if (o_matched !== e.matched) begin
                $display("%0t: matched expected %0b actual %0b", $time, e.matched, o_matched);
                err_cnt++;
            end
            if (o_pattern_overflow !== e.overflow) begin
                $display("%0t: pattern_overflow expected %0b actual %0b",
                         $time, e.overflow, o_pattern_overflow);
                err_cnt++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            check_verdict();
        end
        if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 2);
            mode_left  = $urandom_range(50, 300);
            stall_per  = $urandom_range(2, 8);
            stall_on   = $urandom_range(1, stall_per - 1);
            stall_ph   = 0;
        end
        mode_left--;
        if (!i_rst_n || stall_mode == 0) begin
            i_stall <= 1'b0;
        end else if (stall_mode == 1) begin
            i_stall <= ($urandom_range(0, 2) == 0);
        end else begin
            i_stall  <= (stall_ph < stall_on);
            stall_ph = (stall_ph + 1) % stall_per;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && !(i_valid && !o_stall) && !(o_valid && !i_stall)) begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end else begin
            idle_cycles = 0;
        end
    end

    initial begin
        bit paused;
        int r;
        paused = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[i]) begin
            for (int j = 0; j < plan[i].rep; j++) begin
                drive_item(plan[i].kind, plan[i].sym, plan[i].fixed,
                           '{matched: plan[i].matched, overflow: plan[i].overflow});
            end
        end

        load_random_pattern();
        while (items_sent < ITEM_TARGET) begin
            r = $urandom_range(0, 99);
            if (r < 6) begin
                drive_item(KIND_W'($urandom_range(0, 3)), SYM_W'($urandom_range(0, 255)),
                           1'b0, '0);
            end else if (r < 30) begin
                load_random_pattern();
            end else begin
                send_random_text();
            end
            if (!paused && items_sent >= ITEM_TARGET / 2) begin
                paused = 1'b1;
                i_valid <= 1'b0;
                burst_left = 0;
                do @(posedge i_clk); while (verdict_q.size() != 0);
            end
        end

        i_valid <= 1'b0;
        do @(posedge i_clk); while (verdict_q.size() != 0);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("Sent %0d transactions and checked %0d verdicts.", items_sent, verdicts_seen);
        $display("Verdicts with a match: %0d, with pattern overflow: %0d.", match_seen, ovf_seen);
        if (err_cnt == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/wpm_pkg.sv
hdl/wpm_cell.sv
hdl/wpm_closure.sv
hdl/wildcard_pattern_matcher_unit.sv
hdl/wpm_checker.sv
tb/sv/wildcard_pattern_matcher_unit_tb.sv
